[hdl/shxfe_pkg.sv]
package shxfe_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'h55;
	localparam logic [7:0]  SYNC_SECOND = 8'hAA;
	localparam logic [7:0]  TRAIL_BYTE  = 8'h00;
	localparam logic [15:0] LEN_ADJUST  = 16'd7;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	// byte positions within one frame beat sequence
	localparam logic [2:0] POS_SYNC1 = 3'd0;
	localparam logic [2:0] POS_SYNC2 = 3'd1;
	localparam logic [2:0] POS_LENHI = 3'd2;
	localparam logic [2:0] POS_LENLO = 3'd3;
	localparam logic [2:0] POS_BODY  = 3'd4;
	localparam logic [2:0] POS_TRAIL = 3'd5;
	localparam logic [2:0] POS_CHECK = 3'd6;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       is_start;
		logic       close;
		logic [7:0] len_hi;
		logic [7:0] len_lo;
		logic [7:0] body;
		logic [7:0] check;
	} shxfe_job_t;

endpackage

[hdl/shxfe_front.sv]
module shxfe_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     mode,
	input  logic [15:0]              payload_length,
	input  logic [7:0]               frame_type,
	input  logic [7:0]               payload_byte,
	output logic                     push,
	output shxfe_pkg::shxfe_job_t    job
);

	logic        open_q;
	logic [15:0] remaining_q;
	logic [7:0]  csum_q;

	logic        accept;
	logic [15:0] total;
	logic [7:0]  hdr_sum;
	logic [7:0]  data_sum;
	logic        len_zero;
	logic        data_last;

	assign accept    = in_valid && !in_stall;
	assign total     = payload_length + shxfe_pkg::LEN_ADJUST;
	assign hdr_sum   = shxfe_pkg::SYNC_FIRST ^ shxfe_pkg::SYNC_SECOND ^ total[15:8]
		^ total[7:0] ^ frame_type;
	assign data_sum  = csum_q ^ payload_byte;
	assign len_zero  = (payload_length == 16'd0);
	assign data_last = (remaining_q == 16'd1);

	assign push = accept && ((mode == shxfe_pkg::MODE_START) || open_q);

	always_comb begin
		job.is_start = (mode == shxfe_pkg::MODE_START);
		job.len_hi   = total[15:8];
		job.len_lo   = total[7:0];
		if (mode == shxfe_pkg::MODE_START) begin
			job.close = len_zero;
			job.body  = frame_type;
			job.check = hdr_sum;
		end else begin
			job.close = data_last;
			job.body  = payload_byte;
			job.check = data_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= 16'd0;
			csum_q      <= 8'd0;
		end else if (push) begin
			if (job.close) begin
				open_q      <= 1'b0;
				remaining_q <= 16'd0;
				csum_q      <= 8'd0;
			end else if (mode == shxfe_pkg::MODE_START) begin
				open_q      <= 1'b1;
				remaining_q <= payload_length;
				csum_q      <= hdr_sum;
			end else begin
				remaining_q <= remaining_q - 16'd1;
				csum_q      <= data_sum;
			end
		end
	end

	a_open_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (remaining_q != 16'd0))
		else $error("open frame with no bytes remaining");

endmodule

[hdl/shxfe_queue.sv]
module shxfe_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  shxfe_pkg::shxfe_job_t    wr_job,
	input  logic                     pop,
	output shxfe_pkg::shxfe_job_t    rd_job,
	output logic                     empty,
	output logic                     full
);

	shxfe_pkg::shxfe_job_t              mem_q [shxfe_pkg::QDEPTH];
	logic [shxfe_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [shxfe_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [shxfe_pkg::QCNT_W-1:0]      count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == shxfe_pkg::QCNT_W'(shxfe_pkg::QDEPTH));
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= shxfe_pkg::QCNT_W'(shxfe_pkg::QDEPTH))
		else $error("queue count out of range");

endmodule

[hdl/shxfe_back.sv]
module shxfe_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  shxfe_pkg::shxfe_job_t    job,
	input  logic                     empty,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               out_byte,
	output logic                     frame_done,
	output logic                     run_last
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       done_q;
	logic       last_q;

	logic       advance;
	logic       load;
	logic [2:0] pos;
	logic [2:0] last_pos;
	logic       job_last;
	logic [7:0] sel_byte;

	assign advance  = !valid_q || !out_stall;
	assign load     = advance && !empty;
	assign pos      = job.is_start ? idx_q : idx_q + shxfe_pkg::POS_BODY;
	assign last_pos = job.close ? shxfe_pkg::POS_CHECK : shxfe_pkg::POS_BODY;
	assign job_last = (pos == last_pos);
	assign pop      = load && job_last;

	always_comb begin
		unique case (pos)
			shxfe_pkg::POS_SYNC1: sel_byte = shxfe_pkg::SYNC_FIRST;
			shxfe_pkg::POS_SYNC2: sel_byte = shxfe_pkg::SYNC_SECOND;
			shxfe_pkg::POS_LENHI: sel_byte = job.len_hi;
			shxfe_pkg::POS_LENLO: sel_byte = job.len_lo;
			shxfe_pkg::POS_BODY:  sel_byte = job.body;
			shxfe_pkg::POS_TRAIL: sel_byte = shxfe_pkg::TRAIL_BYTE;
			default:              sel_byte = job.check;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= !empty;
			end
			if (load) begin
				idx_q <= job_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			done_q <= (pos == shxfe_pkg::POS_CHECK);
			last_q <= job_last;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign frame_done = done_q;
	assign run_last   = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= shxfe_pkg::POS_CHECK)
		else $error("byte index out of range");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && done_q |-> last_q)
		else $error("frame close beat not last of its item");

endmodule

[hdl/sync_header_xor_frame_encoder.sv]
// Sync-header frame encoder with XOR check byte.
// Input channel (in_valid / in_stall): mode 0 starts a frame from payload_length
// and frame_type; mode 1 carries one payload_byte. A data beat with no frame open
// is dropped; a start beat abandons any open frame.
// Output channel (out_valid / out_stall): one frame byte per beat. frame_done marks
// the check byte, run_last the final byte caused by one input beat.
// A start beat yields 5 bytes (7 for a zero length), a data beat 1 (3 when final).
// An accepted item enters the job queue, then the output byte register.
// Throughput: one input beat per cycle while each item yields one byte and the
// output is not stalled; the output register emits one byte per cycle unless
// out_stall holds it, so an item holds the back end until all its bytes are out.
// A 4-entry job queue sits between the classifying front end and the byte
// sequencer; in_stall rises only while that queue is full, so the output side
// can stall for a while without stalling the input.
// Reset (arst_n low) empties the queue, closes any frame and clears the checksum.
module sync_header_xor_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] payload_length,
	input  logic [7:0]  frame_type,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_done,
	output logic        run_last
);

	shxfe_pkg::shxfe_job_t wr_job;
	shxfe_pkg::shxfe_job_t rd_job;
	logic                  push;
	logic                  pop;
	logic                  q_empty;
	logic                  q_full;

	assign in_stall = q_full;

	shxfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (q_full),
		.mode           (mode),
		.payload_length (payload_length),
		.frame_type     (frame_type),
		.payload_byte   (payload_byte),
		.push           (push),
		.job            (wr_job)
	);

	shxfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (q_empty),
		.full   (q_full)
	);

	shxfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (rd_job),
		.empty      (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_done (frame_done),
		.run_last   (run_last)
	);

endmodule

[dv/tb_sync_header_xor_frame_encoder.sv]
`timescale 1ns / 1ps

module tb_sync_header_xor_frame_encoder;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;

	class frame_scoreboard;
		typedef struct {
			logic [7:0] data;
			logic       done;
			logic       last;
		} frame_byte_t;

		frame_byte_t    byte_q[$];
		bit             open;
		logic [15:0]    left;
		logic [7:0]     lrc;
		int             errors;
		int             n_live;
		int             n_bytes;
		int             n_frames;
		int             n_dropped;

		function new();
			open = 0;
			left = '0;
			lrc = '0;
			errors = 0;
			n_live = 0;
			n_bytes = 0;
			n_frames = 0;
			n_dropped = 0;
		endfunction

		function void push(logic [7:0] data, logic done);
			frame_byte_t fb;
			fb.data = data;
			fb.done = done;
			fb.last = 1'b0;
			byte_q.push_back(fb);
		endfunction

		function void emit(logic [7:0] data);
			lrc = lrc ^ data;
			push(data, 1'b0);
		endfunction

		function void close_frame();
			push(shxfe_pkg::TRAIL_BYTE, 1'b0);
			push(lrc, 1'b1);
			open = 0;
			left = '0;
			lrc = '0;
			n_frames++;
		endfunction

		// one accepted input beat
		function void note_input(logic m, logic [15:0] len, logic [7:0] ftype,
				logic [7:0] pbyte);
			logic [15:0] total;
			if (m == shxfe_pkg::MODE_START) begin
				total = len + shxfe_pkg::LEN_ADJUST;
				lrc = '0;
				emit(shxfe_pkg::SYNC_FIRST);
				emit(shxfe_pkg::SYNC_SECOND);
				emit(total[15:8]);
				emit(total[7:0]);
				emit(ftype);
				open = 1;
				left = len;
				if (len == 16'd0)
					close_frame();
			end else begin
				if (!open) begin
					n_dropped++;
					return;
				end
				emit(pbyte);
				left = left - 16'd1;
				if (left == 16'd0)
					close_frame();
			end
			byte_q[byte_q.size() - 1].last = 1'b1;
			n_live++;
		endfunction

		// one accepted output beat
		function void check_result(logic [7:0] data, logic done, logic last);
			frame_byte_t fb;
			if (byte_q.size() == 0) begin
				$error("unexpected output beat: out_byte %h frame_done %b run_last %b",
					data, done, last);
				errors++;
				return;
			end
			fb = byte_q.pop_front();
			n_bytes++;
			if (data !== fb.data) begin
				$error("out_byte: expected %h, actual %h", fb.data, data);
				errors++;
			end
			if (done !== fb.done) begin
				$error("frame_done: expected %b, actual %b", fb.done, done);
				errors++;
			end
			if (last !== fb.last) begin
				$error("run_last: expected %b, actual %b", fb.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = shxfe_pkg::MODE_START;
	logic [15:0] payload_length = '0;
	logic [7:0]  frame_type = '0;
	logic [7:0]  payload_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_done;
	logic        run_last;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	frame_scoreboard sb = new();

	sync_header_xor_frame_encoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.payload_length (payload_length),
		.frame_type     (frame_type),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.frame_done     (frame_done),
		.run_last       (run_last)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(mode, payload_length, frame_type, payload_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, frame_done, run_last);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// entered just after a falling edge, returns just after one
	task automatic send_beat(logic m, logic [15:0] len, logic [7:0] ftype,
			logic [7:0] pbyte);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			payload_length = 16'($urandom);
			frame_type = 8'($urandom);
			payload_byte = 8'($urandom);
			mode = 1'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		payload_length = len;
		frame_type = ftype;
		payload_byte = pbyte;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_data(logic [7:0] pbyte);
		send_beat(shxfe_pkg::MODE_DATA, 16'($urandom), 8'($urandom), pbyte);
	endtask

	task automatic send_start(logic [15:0] len, logic [7:0] ftype);
		send_beat(shxfe_pkg::MODE_START, len, ftype, 8'($urandom));
	endtask

	task automatic send_frame(logic [15:0] len, logic [7:0] ftype, int nbytes);
		send_start(len, ftype);
		for (int i = 0; i < nbytes; i++)
			send_data(8'($urandom));
	endtask

	task automatic run_phase(int idle, int stall, int target);
		int goal;
		int pick;
		logic [15:0] len;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		goal = sb.n_live + target;
		while (sb.n_live < goal) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				if ($urandom_range(9) == 0)
					len = 16'($urandom_range(7, 40));
				else
					len = 16'($urandom_range(0, 6));
				send_frame(len, 8'($urandom), int'(len));
			end else if (pick < 87) begin
				// cut short, the next start abandons it
				len = 16'($urandom_range(5, 65535));
				send_frame(len, 8'($urandom), $urandom_range(4));
			end else if (pick < 93) begin
				len = 16'($urandom_range(65529, 65535));
				send_frame(len, 8'($urandom), $urandom_range(2));
			end else begin
				send_data(8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		send_data(8'hFF);
		send_start(16'd0, 8'h00);
		send_start(16'd0, 8'hFF);
		send_start(16'd1, 8'hA5);
		send_data(8'h00);
		send_start(16'd2, 8'h5A);
		send_data(8'hFF);
		send_data(8'h80);
		send_start(16'hFFFF, 8'h3C);
		send_data(8'h12);
		send_start(16'd65529, 8'hC3);
		send_start(16'd3, 8'h01);
		send_data(8'h7F);
		send_data(8'hFE);
		send_data(8'h01);
		send_data(8'h44);
		send_start(16'd65528, 8'h81);
		send_start(16'd0, 8'h18);

		run_phase(0, 0, 100);
		run_phase(70, 0, 100);
		run_phase(0, 70, 100);
		run_phase(12, 12, 100);

		in_valid = 1'b0;
		while (sb.byte_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input beats with output, %0d stray bytes dropped",
			sb.n_live, sb.n_dropped);
		$display("checked %0d output bytes, %0d frames closed, %0d mismatches",
			sb.n_bytes, sb.n_frames, sb.errors);
		if (sb.errors == 0 && sb.byte_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
